[rtl/osvg_pkg.sv]
// Package for the ordered split variance gain scorer.
// Holds datapath widths, state machine types and the request and response
// structs shared by the top level, the multiplier and the divider.
package osvg_pkg;

  localparam int unsigned MAX_OBS_DEF = 64;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned WT_W     = 8;
  localparam int unsigned MB_W     = 7;
  localparam int unsigned GOOD_W   = 17;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned WY_W     = 24;
  localparam int unsigned WYY_W    = 40;
  localparam int unsigned W_W      = 14;
  localparam int unsigned S_W      = 30;
  localparam int unsigned Q_W      = 46;
  localparam int unsigned C_W      = 58;
  localparam int unsigned P_W      = 44;
  localparam int unsigned D_W      = 46;
  localparam int unsigned A_W      = 44;
  localparam int unsigned WLR_W    = 28;
  localparam int unsigned MCAND_W  = 58;
  localparam int unsigned MPLIER_W = 48;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned PROD_W   = 88;
  localparam int unsigned DEN_W    = 84;
  localparam int unsigned REM_W    = 85;
  localparam int unsigned DCNT_W   = 5;

  localparam logic [GOOD_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQUARE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_READ,
    ST_ACC,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_WQ,
    MS_S2,
    MS_P1,
    MS_P2,
    MS_SQ,
    MS_WLR,
    MS_DEN
  } mstep_e;

  typedef struct packed {
    logic                start;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GOOD_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [S_W-1:0] abs_s(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] n;
    n = -v;
    return v[S_W-1] ? S_W'(n) : S_W'(v);
  endfunction

endpackage

[rtl/osvg_mul.sv]
// Shared multiplier that works through the multiplier operand sixteen bits
// per cycle and accumulates the partial products. Uses osvg_pkg.
module osvg_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  osvg_pkg::mul_req_t req_i,
  output osvg_pkg::mul_rsp_t rsp_o
);

  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [1:0] idx_q, idx_d;
  logic [osvg_pkg::MCAND_W-1:0] mcand_q, mcand_d;
  logic [osvg_pkg::MPLIER_W-1:0] mpl_q, mpl_d;
  logic [osvg_pkg::PROD_W-1:0] acc_q, acc_d;
  logic [osvg_pkg::MCAND_W+osvg_pkg::CHUNK_W-1:0] pp;
  logic [osvg_pkg::PROD_W-1:0] pp_sh;
  logic [osvg_pkg::MPLIER_W-1:0] mpl_next;

  always_comb begin
    pp = {{osvg_pkg::CHUNK_W{1'b0}}, mcand_q} *
         {{osvg_pkg::MCAND_W{1'b0}}, mpl_q[osvg_pkg::CHUNK_W-1:0]};
    pp_sh = osvg_pkg::PROD_W'(pp) << {idx_q, 4'b0000};
    mpl_next = mpl_q >> osvg_pkg::CHUNK_W;
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    idx_d   = idx_q;
    mcand_d = mcand_q;
    mpl_d   = mpl_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      idx_d   = 2'd0;
      mcand_d = req_i.mcand;
      mpl_d   = req_i.mplier;
      acc_d   = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      mpl_d = mpl_next;
      idx_d = idx_q + 2'd1;
      if (mpl_next == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mpl_q   <= mpl_d;
    acc_q   <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

[rtl/osvg_div.sv]
// Restoring divider that forms a Q1.16 ratio one quotient bit per cycle,
// clamped to one. Uses osvg_pkg.
module osvg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  osvg_pkg::div_req_t req_i,
  output osvg_pkg::div_rsp_t rsp_o
);

  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [osvg_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [osvg_pkg::REM_W-1:0] r_q, r_d;
  logic [osvg_pkg::DEN_W-1:0] den_q, den_d;
  logic [osvg_pkg::GOOD_W-1:0] quo_q, quo_d;
  logic over;
  logic ge;
  logic [osvg_pkg::REM_W-1:0] rsel;

  always_comb begin
    over = req_i.num >= osvg_pkg::PROD_W'({req_i.den, 1'b0});
    ge   = r_q >= osvg_pkg::REM_W'(den_q);
    rsel = ge ? (r_q - osvg_pkg::REM_W'(den_q)) : r_q;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      if (over) begin
        quo_d  = osvg_pkg::Q16_ONE;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = osvg_pkg::DCNT_W'(osvg_pkg::GOOD_W);
        r_d    = osvg_pkg::REM_W'(req_i.num);
        den_d  = req_i.den;
        quo_d  = '0;
      end
    end else if (busy_q) begin
      r_d   = {rsel[osvg_pkg::REM_W-2:0], 1'b0};
      quo_d = {quo_q[osvg_pkg::GOOD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == osvg_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = (quo_q > osvg_pkg::Q16_ONE) ? osvg_pkg::Q16_ONE : quo_q;

endmodule

[rtl/ordered_split_variance_gain.sv]
// Ordered split variance gain scorer: top level with sequencer and sample store.
// Each observation passes through the load and square states before the next one is
// accepted. After the last observation two products set up the total variance, then
// each scored split point takes five shared multiplier passes, a divide and an output
// state, while a suppressed one goes from the check straight to the output state.
// Reset clears the total sums, counts and split index and sets min_bucket to one; the store is not cleared.
module ordered_split_variance_gain #(
  parameter int unsigned MAX_OBS = osvg_pkg::MAX_OBS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [osvg_pkg::MB_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [osvg_pkg::VAL_W-1:0]   sample_value_i,
  input  logic [osvg_pkg::WT_W-1:0]           case_weight_i,
  input  logic                                last_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [osvg_pkg::GOOD_W-1:0]         goodness_o,
  output logic [osvg_pkg::POS_W-1:0]          split_position_o,
  output logic                                last_result_o
);

  localparam int unsigned AW    = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_OBS + 1);

  osvg_pkg::state_e state_q, state_d;
  osvg_pkg::mstep_e mstep_q, mstep_d;

  logic [osvg_pkg::MB_W-1:0] mb_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [osvg_pkg::W_W-1:0] totw_q, totw_d;
  logic signed [osvg_pkg::S_W-1:0] wsum_q, wsum_d;
  logic [osvg_pkg::Q_W-1:0] wsq_q, wsq_d;
  logic [AW-1:0] k_q, k_d;

  logic signed [osvg_pkg::VAL_W-1:0] y_q, y_d;
  logic [osvg_pkg::WT_W-1:0] wt_q, wt_d;
  logic last_q, last_d;
  logic keep_q, keep_d;
  logic signed [osvg_pkg::WY_W-1:0] wy_q, wy_d;
  logic [osvg_pkg::W_W-1:0] wl_q, wl_d;
  logic signed [osvg_pkg::S_W-1:0] sl_q, sl_d;
  logic [osvg_pkg::C_W-1:0] c_q, c_d;
  logic [osvg_pkg::P_W-1:0] p1_q, p1_d;
  logic [osvg_pkg::A_W-1:0] a_q, a_d;
  logic [osvg_pkg::PROD_W-1:0] num_q, num_d;
  logic [osvg_pkg::WLR_W-1:0] wlwr_q, wlwr_d;
  logic [osvg_pkg::GOOD_W-1:0] g_q, g_d;

  logic [osvg_pkg::VAL_W-1:0] val_mem [MAX_OBS];
  logic [osvg_pkg::WT_W-1:0] wt_mem [MAX_OBS];
  logic [osvg_pkg::VAL_W-1:0] rd_val_q;
  logic [osvg_pkg::WT_W-1:0] rd_wt_q;
  logic mem_we;

  osvg_pkg::mul_req_t mul_req;
  osvg_pkg::mul_rsp_t mul_rsp;
  osvg_pkg::div_req_t div_req;
  osvg_pkg::div_rsp_t div_rsp;

  logic signed [osvg_pkg::WY_W:0] wy_new;
  logic signed [osvg_pkg::WY_W:0] rd_wy;
  logic signed [osvg_pkg::WYY_W-1:0] wyy;
  logic [osvg_pkg::W_W-1:0] wr;
  logic [osvg_pkg::S_W-1:0] abs_sum;
  logic [osvg_pkg::S_W-1:0] abs_sl;
  logic [osvg_pkg::C_W-1:0] prod_c;
  logic signed [osvg_pkg::D_W-1:0] sp1, sp2, dd, dneg;
  logic [osvg_pkg::MB_W:0] kp1, rcnt;
  logic score_ok;
  logic is_last;

  osvg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  osvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    wy_new  = $signed({1'b0, wt_q}) * y_q;
    rd_wy   = $signed({1'b0, rd_wt_q}) * $signed(rd_val_q);
    wyy     = wy_q * y_q;
    wr      = totw_q - wl_q;
    abs_sum = osvg_pkg::abs_s(wsum_q);
    abs_sl  = osvg_pkg::abs_s(sl_q);
    prod_c  = osvg_pkg::C_W'(mul_rsp.product);
    sp1     = sl_q[osvg_pkg::S_W-1] ? -$signed({2'b00, p1_q}) : $signed({2'b00, p1_q});
    sp2     = wsum_q[osvg_pkg::S_W-1] ?
              -$signed({2'b00, mul_rsp.product[osvg_pkg::P_W-1:0]}) :
              $signed({2'b00, mul_rsp.product[osvg_pkg::P_W-1:0]});
    dd      = sp1 - sp2;
    dneg    = -dd;
    kp1     = (osvg_pkg::MB_W+1)'(k_q) + 1'b1;
    rcnt    = (osvg_pkg::MB_W+1)'(cnt_q) - kp1;
    score_ok = (kp1 >= {1'b0, mb_q}) && (rcnt >= {1'b0, mb_q}) &&
               (wl_q != '0) && (wr != '0) && (c_q != '0);
    is_last = ((CNT_W+1)'(k_q) + (CNT_W+1)'(2)) == (CNT_W+1)'(cnt_q);
  end

  always_comb begin
    mul_req.start  = (state_q == osvg_pkg::ST_MUL_GO);
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    unique case (mstep_q)
      osvg_pkg::MS_WQ: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(wsq_q);
        mul_req.mplier = osvg_pkg::MPLIER_W'(totw_q);
      end
      osvg_pkg::MS_S2: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(abs_sum);
        mul_req.mplier = osvg_pkg::MPLIER_W'(abs_sum);
      end
      osvg_pkg::MS_P1: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(abs_sl);
        mul_req.mplier = osvg_pkg::MPLIER_W'(totw_q);
      end
      osvg_pkg::MS_P2: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(abs_sum);
        mul_req.mplier = osvg_pkg::MPLIER_W'(wl_q);
      end
      osvg_pkg::MS_SQ: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(a_q);
        mul_req.mplier = osvg_pkg::MPLIER_W'(a_q);
      end
      osvg_pkg::MS_WLR: begin
        mul_req.mcand  = osvg_pkg::MCAND_W'(wl_q);
        mul_req.mplier = osvg_pkg::MPLIER_W'(wr);
      end
      osvg_pkg::MS_DEN: begin
        mul_req.mcand  = c_q;
        mul_req.mplier = osvg_pkg::MPLIER_W'(wlwr_q);
      end
      default: begin
        mul_req.mcand  = '0;
        mul_req.mplier = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      osvg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = osvg_pkg::ST_LOAD;
      end
      osvg_pkg::ST_LOAD: state_d = osvg_pkg::ST_SQUARE;
      osvg_pkg::ST_SQUARE: begin
        if (last_q && cnt_q >= CNT_W'(2)) state_d = osvg_pkg::ST_MUL_GO;
        else state_d = osvg_pkg::ST_IDLE;
      end
      osvg_pkg::ST_MUL_GO: state_d = osvg_pkg::ST_MUL_WAIT;
      osvg_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          if (mstep_q == osvg_pkg::MS_S2) state_d = osvg_pkg::ST_READ;
          else if (mstep_q == osvg_pkg::MS_DEN) state_d = osvg_pkg::ST_DIV_WAIT;
          else state_d = osvg_pkg::ST_MUL_GO;
        end
      end
      osvg_pkg::ST_READ: state_d = osvg_pkg::ST_ACC;
      osvg_pkg::ST_ACC: state_d = osvg_pkg::ST_CHECK;
      osvg_pkg::ST_CHECK: begin
        if (score_ok) state_d = osvg_pkg::ST_MUL_GO;
        else state_d = osvg_pkg::ST_OUT;
      end
      osvg_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) state_d = osvg_pkg::ST_OUT;
      end
      osvg_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (is_last) state_d = osvg_pkg::ST_IDLE;
          else state_d = osvg_pkg::ST_READ;
        end
      end
      default: state_d = osvg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != osvg_pkg::ST_IDLE);
    out_valid_o   = (state_q == osvg_pkg::ST_OUT);
    mem_we        = (state_q == osvg_pkg::ST_LOAD) && keep_q;
    div_req.start = (state_q == osvg_pkg::ST_MUL_WAIT) && mul_rsp.done &&
                    (mstep_q == osvg_pkg::MS_DEN);
    div_req.num   = num_q;
    div_req.den   = osvg_pkg::DEN_W'(mul_rsp.product);
  end

  always_comb begin
    mstep_d = mstep_q;
    cnt_d   = cnt_q;
    totw_d  = totw_q;
    wsum_d  = wsum_q;
    wsq_d   = wsq_q;
    k_d     = k_q;
    y_d     = y_q;
    wt_d    = wt_q;
    last_d  = last_q;
    keep_d  = keep_q;
    wy_d    = wy_q;
    wl_d    = wl_q;
    sl_d    = sl_q;
    c_d     = c_q;
    p1_d    = p1_q;
    a_d     = a_q;
    num_d   = num_q;
    wlwr_d  = wlwr_q;
    g_d     = g_q;
    unique case (state_q)
      osvg_pkg::ST_IDLE: begin
        y_d    = sample_value_i;
        wt_d   = case_weight_i;
        last_d = last_item_i;
        keep_d = cnt_q < CNT_W'(MAX_OBS);
      end
      osvg_pkg::ST_LOAD: begin
        wy_d = osvg_pkg::WY_W'(wy_new);
        if (keep_q) begin
          cnt_d  = cnt_q + 1'b1;
          totw_d = totw_q + osvg_pkg::W_W'(wt_q);
          wsum_d = wsum_q + osvg_pkg::S_W'(wy_new);
        end
      end
      osvg_pkg::ST_SQUARE: begin
        if (keep_q) wsq_d = wsq_q + osvg_pkg::Q_W'($unsigned(wyy));
        mstep_d = osvg_pkg::MS_WQ;
        if (last_q && cnt_q < CNT_W'(2)) begin
          cnt_d  = '0;
          totw_d = '0;
          wsum_d = '0;
          wsq_d  = '0;
        end
      end
      osvg_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          unique case (mstep_q)
            osvg_pkg::MS_WQ: begin
              c_d     = prod_c;
              mstep_d = osvg_pkg::MS_S2;
            end
            osvg_pkg::MS_S2: begin
              c_d  = (c_q > prod_c) ? (c_q - prod_c) : '0;
              k_d  = '0;
              sl_d = '0;
              wl_d = '0;
            end
            osvg_pkg::MS_P1: begin
              p1_d    = osvg_pkg::P_W'(mul_rsp.product);
              mstep_d = osvg_pkg::MS_P2;
            end
            osvg_pkg::MS_P2: begin
              a_d     = dd[osvg_pkg::D_W-1] ? osvg_pkg::A_W'(dneg) : osvg_pkg::A_W'(dd);
              mstep_d = osvg_pkg::MS_SQ;
            end
            osvg_pkg::MS_SQ: begin
              num_d   = mul_rsp.product;
              mstep_d = osvg_pkg::MS_WLR;
            end
            osvg_pkg::MS_WLR: begin
              wlwr_d  = osvg_pkg::WLR_W'(mul_rsp.product);
              mstep_d = osvg_pkg::MS_DEN;
            end
            osvg_pkg::MS_DEN: mstep_d = osvg_pkg::MS_P1;
            default: mstep_d = osvg_pkg::MS_P1;
          endcase
        end
      end
      osvg_pkg::ST_ACC: begin
        sl_d = sl_q + osvg_pkg::S_W'(rd_wy);
        wl_d = wl_q + osvg_pkg::W_W'(rd_wt_q);
      end
      osvg_pkg::ST_CHECK: begin
        mstep_d = osvg_pkg::MS_P1;
        if (!score_ok) g_d = '0;
      end
      osvg_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) g_d = div_rsp.quot;
      end
      osvg_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (is_last) begin
            cnt_d  = '0;
            totw_d = '0;
            wsum_d = '0;
            wsq_d  = '0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        mstep_d = mstep_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osvg_pkg::ST_IDLE;
      mstep_q <= osvg_pkg::MS_WQ;
      mb_q    <= osvg_pkg::MB_W'(1);
      cnt_q   <= '0;
      totw_q  <= '0;
      wsum_q  <= '0;
      wsq_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      if (cfg_we_i) mb_q <= cfg_wdata_i;
      cnt_q   <= cnt_d;
      totw_q  <= totw_d;
      wsum_q  <= wsum_d;
      wsq_q   <= wsq_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    wt_q   <= wt_d;
    last_q <= last_d;
    keep_q <= keep_d;
    wy_q   <= wy_d;
    wl_q   <= wl_d;
    sl_q   <= sl_d;
    c_q    <= c_d;
    p1_q   <= p1_d;
    a_q    <= a_d;
    num_q  <= num_d;
    wlwr_q <= wlwr_d;
    g_q    <= g_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[cnt_q[AW-1:0]] <= y_q;
      wt_mem[cnt_q[AW-1:0]]  <= wt_q;
    end
    rd_val_q <= val_mem[k_q];
    rd_wt_q  <= wt_mem[k_q];
  end

  assign goodness_o       = g_q;
  assign split_position_o = osvg_pkg::POS_W'(k_q);
  assign last_result_o    = is_last;

endmodule

[sim/ordered_split_variance_gain_tb.sv]
// Testbench for the ordered split variance gain scorer.
// Predicts every split score of each observation run and checks the block's
// scores in order. Depends on osvg_pkg and ordered_split_variance_gain.
`timescale 1ns / 1ps

module ordered_split_variance_gain_tb;

  localparam int unsigned OBS_MAX = osvg_pkg::MAX_OBS_DEF;
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [osvg_pkg::GOOD_W-1:0] goodness;
    logic [osvg_pkg::POS_W-1:0]  position;
    logic                        last;
  } score_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [osvg_pkg::MB_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [osvg_pkg::VAL_W-1:0] sample_value;
  logic [osvg_pkg::WT_W-1:0] case_weight;
  logic last_item;
  logic out_valid;
  logic out_stall;
  logic [osvg_pkg::GOOD_W-1:0] goodness;
  logic [osvg_pkg::POS_W-1:0] split_position;
  logic last_result;

  score_t expected_scores[$];
  logic signed [osvg_pkg::VAL_W-1:0] run_values[OBS_MAX];
  logic [osvg_pkg::WT_W-1:0] run_weights[OBS_MAX];
  int unsigned run_count;
  int unsigned bucket_floor;
  int unsigned stall_left;
  bit failed;
  bit quiet;

  ordered_split_variance_gain dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .sample_value_i(sample_value),
    .case_weight_i(case_weight),
    .last_item_i(last_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .goodness_o(goodness),
    .split_position_o(split_position),
    .last_result_o(last_result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [osvg_pkg::GOOD_W-1:0] variance_fraction(
    input logic [255:0] num, input logic [255:0] den
  );
    logic [255:0] q;
    q = (num << 16) / den;
    return (q > 256'd65536) ? osvg_pkg::Q16_ONE : osvg_pkg::GOOD_W'(q);
  endfunction

  task automatic score_run();
    logic signed [63:0] s_tot, s_left, d, y64;
    logic [63:0] w_tot, w_left, w_right, q_tot, c_var, d_abs;
    logic signed [127:0] wq, s2;
    score_t sc;
    s_tot = 0;
    w_tot = 0;
    q_tot = 0;
    s_left = 0;
    w_left = 0;
    for (int i = 0; i < run_count; i++) begin
      y64 = run_values[i];
      w_tot += run_weights[i];
      s_tot += $signed({1'b0, run_weights[i]}) * run_values[i];
      q_tot += run_weights[i] * y64 * y64;
    end
    wq = $signed({64'd0, w_tot * q_tot});
    s2 = s_tot * s_tot;
    c_var = (wq > s2) ? 64'(wq - s2) : 64'd0;
    for (int k = 0; run_count >= 2 && k + 1 < run_count; k++) begin
      s_left += $signed({1'b0, run_weights[k]}) * run_values[k];
      w_left += run_weights[k];
      w_right = w_tot - w_left;
      sc.goodness = '0;
      if (k + 1 >= bucket_floor && run_count - k - 1 >= bucket_floor && w_left != 0
          && w_right != 0 && c_var != 0) begin
        d = s_left * $signed(w_tot) - s_tot * $signed(w_left);
        d_abs = d < 0 ? -d : d;
        sc.goodness = variance_fraction(256'(d_abs) * 256'(d_abs),
                                        256'(w_left * w_right) * 256'(c_var));
      end
      sc.position = osvg_pkg::POS_W'(k);
      sc.last = (k + 2 == run_count);
      expected_scores.push_back(sc);
    end
    run_count = 0;
  endtask

  task automatic send_obs(input logic signed [osvg_pkg::VAL_W-1:0] v,
                          input logic [osvg_pkg::WT_W-1:0] w, input logic fin);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    case_weight <= w;
    last_item <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (run_count < OBS_MAX) begin
      run_values[run_count] = v;
      run_weights[run_count] = w;
      run_count++;
    end
    if (fin) score_run();
    in_valid <= 1'b0;
  endtask

  task automatic send_run(input int unsigned len, input bit extreme);
    logic signed [osvg_pkg::VAL_W-1:0] v;
    logic [osvg_pkg::WT_W-1:0] w;
    for (int i = 0; i < len; i++) begin
      v = extreme ? ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : $urandom;
      w = $urandom_range(0, 7) == 0 ? 8'd0 : $urandom;
      send_obs(v, w, i == len - 1);
    end
  endtask

  task automatic set_min_bucket(input logic [osvg_pkg::MB_W-1:0] value);
    wait (expected_scores.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bucket_floor = value;
  endtask

  task automatic test_extremes();
    send_obs(16'sh7fff, 8'd255, 1'b0);
    send_obs(16'sh8000, 8'd255, 1'b0);
    send_obs(16'sh0000, 8'd1, 1'b0);
    send_obs(16'sh7fff, 8'd0, 1'b1);
    send_obs(16'sh1234, 8'd5, 1'b1);
    send_obs(16'sh0005, 8'd3, 1'b0);
    send_obs(16'sh0005, 8'd9, 1'b0);
    send_obs(16'sh0005, 8'd1, 1'b1);
    send_obs(16'sh0001, 8'd0, 1'b0);
    send_obs(16'sh0002, 8'd0, 1'b0);
    send_obs(16'sh0003, 8'd4, 1'b1);
    send_obs(-16'sd7, 8'd2, 1'b0);
    send_obs(16'sd9, 8'd0, 1'b0);
    send_obs(16'sd9, 8'd6, 1'b1);
  endtask

  task automatic test_min_bucket();
    set_min_bucket(7'd0);
    send_run(5, 1'b0);
    set_min_bucket(7'd3);
    send_run(8, 1'b0);
    set_min_bucket(7'd64);
    send_run(4, 1'b0);
    set_min_bucket(7'd127);
    send_run(6, 1'b0);
    set_min_bucket(7'd1);
  endtask

  task automatic test_overlong();
    send_run(66, 1'b1);
  endtask

  task automatic test_random();
    for (int r = 0; r < 6; r++) begin
      if (r == 4) quiet = 1'b1;
      if (r == 2) set_min_bucket(osvg_pkg::MB_W'($urandom_range(0, 4)));
      send_run($urandom_range(1, 6), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected score at position %0d", split_position);
        failed = 1'b1;
      end else begin
        want = expected_scores.pop_front();
        if (goodness !== want.goodness) begin
          $error("goodness expected %0d actual %0d", want.goodness, goodness);
          failed = 1'b1;
        end
        if (split_position !== want.position) begin
          $error("split_position expected %0d actual %0d", want.position, split_position);
          failed = 1'b1;
        end
        if (last_result !== want.last) begin
          $error("last_result expected %0d actual %0d", want.last, last_result);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    failed = 1'b0;
    quiet = 1'b0;
    run_count = 0;
    bucket_floor = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    sample_value = '0;
    case_weight = '0;
    last_item = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_min_bucket();
    test_overlong();
    test_random();
    wait (expected_scores.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && expected_scores.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
